### hw/rtl/ps2c_pkg.sv
// Shared types and constants for the dual-ring PS/2 controller.
package ps2c_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned BYTE_W = 8;

  // Item selector codes
  localparam logic [CMD_W-1:0] CMD_PUSH_KBD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_AUX   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ_DATA  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_STAT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE_DATA = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WRITE_CMD  = 3'd5;

  // Controller commands
  localparam logic [BYTE_W-1:0] KC_WRITE_CMD_BYTE = 8'h60;
  localparam logic [BYTE_W-1:0] KC_AUX_DISABLE    = 8'hA7;
  localparam logic [BYTE_W-1:0] KC_AUX_ENABLE     = 8'hA8;
  localparam logic [BYTE_W-1:0] KC_KBD_DISABLE    = 8'hAD;
  localparam logic [BYTE_W-1:0] KC_KBD_ENABLE     = 8'hAE;
  localparam logic [BYTE_W-1:0] KC_AUX_WRITE      = 8'hD4;

  // Status bits
  localparam logic [BYTE_W-1:0] ST_OBF     = 8'h01;
  localparam logic [BYTE_W-1:0] ST_RESET   = 8'h10;
  localparam logic [BYTE_W-1:0] ST_AUX_OBF = 8'h20;

  // Config register indexes
  localparam logic REG_KBD_PRESENT = 1'b0;
  localparam logic REG_AUX_PRESENT = 1'b1;

  typedef struct packed {
    logic push;
    logic pop;
    logic rd_en;
  } ring_ctrl_t;

  typedef struct packed {
    logic empty;
    logic empty_next;
  } ring_stat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] cmd_byte;
    logic              kbd_en;
    logic              aux_en;
    logic              aux_expect;
  } cmd_flags_t;

endpackage

### hw/rtl/ps2c_if.sv
// Item channel interfaces: request side and result side.
interface ps2c_in_if
  import ps2c_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output cmd, output byte_in, input ready);
  modport sink   (input valid, input cmd, input byte_in, output ready);
endinterface

interface ps2c_out_if
  import ps2c_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic              irq_pulse;
  logic [BYTE_W-1:0] controller_command_byte;
  logic              kbd_port_enabled;
  logic              aux_port_enabled;
  logic              aux_write_expected;

  modport source (output valid, output read_byte, output irq_pulse,
                  output controller_command_byte, output kbd_port_enabled,
                  output aux_port_enabled, output aux_write_expected, input ready);
  modport sink   (input valid, input read_byte, input irq_pulse,
                  input controller_command_byte, input kbd_port_enabled,
                  input aux_port_enabled, input aux_write_expected, output ready);
endinterface

### hw/rtl/ps2c_ring.sv
// Byte ring: storage, read/write pointers, overwrite-oldest on full.
module ps2c_ring
  import ps2c_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ring_ctrl_t        ctrl_i,
  input  logic [BYTE_W-1:0] wdata_i,
  output logic [BYTE_W-1:0] rdata_o,
  output ring_stat_t        stat_o
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  logic [BYTE_W-1:0] mem [RING_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic [PTR_W-1:0]  rd_q, rd_d, wr_q, wr_d;
  logic [PTR_W-1:0]  rd_nx, wr_nx;

  assign rd_nx = (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
  assign wr_nx = (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;

  always_comb begin
    rd_d = rd_q;
    wr_d = wr_q;
    if (ctrl_i.push) begin
      wr_d = wr_nx;
      if (wr_nx == rd_q) begin
        rd_d = rd_nx;  // full: drop oldest
      end
    end else if (ctrl_i.pop) begin
      rd_d = rd_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
    end else begin
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wr_q] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[rd_q];
    end
  end

  assign rdata_o           = rdata_q;
  assign stat_o.empty      = (rd_q == wr_q);
  assign stat_o.empty_next = (rd_d == wr_d);

endmodule

### hw/rtl/ps2c_cmd.sv
// Command decode: pending command, command byte and port flags.
module ps2c_cmd
  import ps2c_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_data_i,
  input  logic              wr_cmd_i,
  input  logic [BYTE_W-1:0] byte_i,
  output cmd_flags_t        flags_d_o
);

  logic [BYTE_W-1:0] pending_q, pending_d;
  cmd_flags_t        flags_q, flags_d;

  always_comb begin
    pending_d = pending_q;
    flags_d   = flags_q;
    if (wr_data_i) begin
      if (pending_q == KC_WRITE_CMD_BYTE) begin
        flags_d.cmd_byte = byte_i;
      end
      pending_d = '0;
    end else if (wr_cmd_i) begin
      pending_d = byte_i;
      case (byte_i)
        KC_AUX_DISABLE: flags_d.aux_en     = 1'b0;
        KC_AUX_ENABLE:  flags_d.aux_en     = 1'b1;
        KC_KBD_DISABLE: flags_d.kbd_en     = 1'b0;
        KC_KBD_ENABLE:  flags_d.kbd_en     = 1'b1;
        KC_AUX_WRITE:   flags_d.aux_expect = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q          <= '0;
      flags_q.cmd_byte   <= '0;
      flags_q.kbd_en     <= 1'b1;
      flags_q.aux_en     <= 1'b1;
      flags_q.aux_expect <= 1'b0;
    end else begin
      pending_q <= pending_d;
      flags_q   <= flags_d;
    end
  end

  assign flags_d_o = flags_d;

endmodule

### hw/rtl/ps2_controller_dual_fifo.sv
// Top level: 8042-style PS/2 controller with keyboard and mouse byte rings.
// Path: an accepted item's result passes the ring read register, then the
//   output register, before it can be taken.
// Throughput: one item per cycle while out_o is not stalled; set by the single ring read port per ring.
// Reset: rst_ni async low; pointers empty, status 0x10, both ports enabled,
//   both devices present. Ring contents are not cleared (no clearing pass).
module ps2_controller_dual_fifo
  import ps2c_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item channels
  ps2c_in_if.sink     in_i,
  ps2c_out_if.source  out_o
);

  // ---------------- config registers ----------------
  logic kbd_present_q, aux_present_q;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kbd_present_q <= 1'b1;
      aux_present_q <= 1'b1;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_KBD_PRESENT: kbd_present_q <= pwdata[0];
        REG_AUX_PRESENT: aux_present_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_KBD_PRESENT: prdata = {31'b0, kbd_present_q};
      REG_AUX_PRESENT: prdata = {31'b0, aux_present_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  // s1 holds an accepted item while the ring read data lands; out holds the
  // finished result. s1 advances whenever the output register is free.
  logic s1_valid_q, s1_adv, accept;
  logic out_valid_q;

  assign s1_adv    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign accept    = in_i.valid && in_i.ready;

  // ---------------- item decode ----------------
  logic is_push_k, is_push_a, is_rd, is_stat, is_wdata, is_wcmd;

  assign is_push_k = accept && (in_i.cmd == CMD_PUSH_KBD) && kbd_present_q;
  assign is_push_a = accept && (in_i.cmd == CMD_PUSH_AUX) && aux_present_q;
  assign is_rd     = accept && (in_i.cmd == CMD_READ_DATA);
  assign is_stat   = accept && (in_i.cmd == CMD_READ_STAT);
  assign is_wdata  = accept && (in_i.cmd == CMD_WRITE_DATA);
  assign is_wcmd   = accept && (in_i.cmd == CMD_WRITE_CMD);

  // ---------------- rings ----------------
  ring_ctrl_t        kbd_ctrl, aux_ctrl;
  ring_stat_t        kbd_stat, aux_stat;
  logic [BYTE_W-1:0] kbd_rdata, aux_rdata;

  // Keyboard ring drains first on a data read.
  assign kbd_ctrl.push  = is_push_k;
  assign kbd_ctrl.pop   = is_rd && !kbd_stat.empty;
  assign kbd_ctrl.rd_en = accept;
  assign aux_ctrl.push  = is_push_a;
  assign aux_ctrl.pop   = is_rd && kbd_stat.empty && !aux_stat.empty;
  assign aux_ctrl.rd_en = accept;

  ps2c_ring #(.RING_DEPTH(RING_DEPTH)) u_kbd_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (kbd_ctrl),
    .wdata_i (in_i.byte_in),
    .rdata_o (kbd_rdata),
    .stat_o  (kbd_stat)
  );

  ps2c_ring #(.RING_DEPTH(RING_DEPTH)) u_aux_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (aux_ctrl),
    .wdata_i (in_i.byte_in),
    .rdata_o (aux_rdata),
    .stat_o  (aux_stat)
  );

  // ---------------- command / flags ----------------
  cmd_flags_t flags_d;

  ps2c_cmd u_cmd (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_data_i (is_wdata),
    .wr_cmd_i  (is_wcmd),
    .byte_i    (in_i.byte_in),
    .flags_d_o (flags_d)
  );

  // ---------------- status / irq ----------------
  // Status always tracks the ring pointers, so it is derived, not stored.
  logic [BYTE_W-1:0] status_byte;
  logic              irq_d;

  always_comb begin
    status_byte = ST_RESET;
    if (!kbd_stat.empty || !aux_stat.empty) begin
      status_byte = status_byte | ST_OBF;
    end
    if (kbd_stat.empty && !aux_stat.empty) begin
      status_byte = status_byte | ST_AUX_OBF;
    end
  end

  assign irq_d = (is_push_k || is_push_a || is_rd) &&
                 !(kbd_stat.empty_next && aux_stat.empty_next);

  // ---------------- stage 1 ----------------
  logic              s1_src_k_q, s1_src_a_q, s1_irq_q;
  logic [BYTE_W-1:0] s1_byte_q;
  cmd_flags_t        s1_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_src_k_q <= kbd_ctrl.pop;
      s1_src_a_q <= aux_ctrl.pop;
      s1_irq_q   <= irq_d;
      s1_byte_q  <= is_stat ? status_byte : '0;
      s1_flags_q <= flags_d;
    end
  end

  // ---------------- output register ----------------
  logic [BYTE_W-1:0] rb_d, out_rb_q;
  logic              out_irq_q;
  cmd_flags_t        out_flags_q;

  assign rb_d = s1_src_k_q ? kbd_rdata :
                s1_src_a_q ? aux_rdata : s1_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_rb_q    <= rb_d;
      out_irq_q   <= s1_irq_q;
      out_flags_q <= s1_flags_q;
    end
  end

  assign out_o.valid                   = out_valid_q;
  assign out_o.read_byte               = out_rb_q;
  assign out_o.irq_pulse               = out_irq_q;
  assign out_o.controller_command_byte = out_flags_q.cmd_byte;
  assign out_o.kbd_port_enabled        = out_flags_q.kbd_en;
  assign out_o.aux_port_enabled        = out_flags_q.aux_en;
  assign out_o.aux_write_expected      = out_flags_q.aux_expect;

endmodule

### hw/rtl/ps2c_checker.sv
// Port-level checker for the PS/2 controller, bound to the top level.
module ps2c_checker
  import ps2c_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] out_read_byte_i,
  input logic              out_irq_i,
  input logic              out_aux_expect_i
);

  logic [1:0] inflight_q;
  logic       aux_seen_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
      aux_seen_q <= 1'b0;
    end else begin
      inflight_q <= inflight_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc && out_aux_expect_i) begin
        aux_seen_q <= 1'b1;
      end
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_read_byte_i) && $stable(out_irq_i))
    else $error("result changed while stalled");

  // no result without an item behind it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 2'd0)
    else $error("result without accepted item");

  // at most two items inside
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q != 2'd3)
    else $error("too many items in flight");

  // aux-write flag is sticky until reset
  a_aux_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && aux_seen_q |-> out_aux_expect_i)
    else $error("aux write flag cleared");

endmodule

bind ps2_controller_dual_fifo ps2c_checker u_ps2c_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_read_byte_i  (out_o.read_byte),
  .out_irq_i        (out_o.irq_pulse),
  .out_aux_expect_i (out_o.aux_write_expected)
);
